// File: hdl/sync_frame_parser_fletcher_defines.svh
// assertion helpers used by the top-level parser file
`ifndef SYNC_FRAME_PARSER_FLETCHER_DEFINES_SVH
`define SYNC_FRAME_PARSER_FLETCHER_DEFINES_SVH

// same-cycle implication
`define SFPF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define SFPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hdl/sfpf_pkg.sv
package sfpf_pkg;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_SYNC3   = 4'd2,
        PH_RQID1   = 4'd3,
        PH_RQID2   = 4'd4,
        PH_RQID3   = 4'd5,
        PH_RQID4   = 4'd6,
        PH_LEN     = 4'd7,
        PH_ROWS    = 4'd8,
        PH_FLOATS  = 4'd9,
        PH_PAYLOAD = 4'd10,
        PH_CHECK1  = 4'd11,
        PH_CHECK2  = 4'd12
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_CSUM = 2'd2,
        KIND_LEN  = 2'd3
    } t_kind;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_FIRST_SYNC  = 3'd0;
    localparam logic [2:0] REG_SECOND_SYNC = 3'd1;
    localparam logic [2:0] REG_CMD_MARKER  = 3'd2;
    localparam logic [2:0] REG_DUMP_MARKER = 3'd3;
    localparam logic [2:0] REG_DUMP_CODE   = 3'd4;

    localparam int ADDR_W = 5;
    localparam int LEN_W  = 18;

    typedef struct packed {
        logic [7:0] first_sync;
        logic [7:0] second_sync;
        logic [7:0] cmd_marker;
        logic [7:0] dump_marker;
        logic [7:0] dump_code;
    } t_cfg;

    typedef struct packed {
        t_kind             result_kind;
        logic              frame_type;
        logic [7:0]        byte_value;
        logic [7:0]        byte_index;
        logic [31:0]       request_tag;
        logic [LEN_W-1:0]  frame_length;
        logic [31:0]       error_total;
    } t_result;

endpackage

// File: hdl/sfpf_cfg.sv
module sfpf_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [sfpf_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready,
    output sfpf_pkg::t_cfg              o_cfg
);

    sfpf_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;
    logic [7:0]     rd_byte;

    assign reg_idx  = i_paddr[sfpf_pkg::ADDR_W-1:2];
    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_sync  <= 8'd65;
            r_cfg.second_sync <= 8'd113;
            r_cfg.cmd_marker  <= 8'd67;
            r_cfg.dump_marker <= 8'd70;
            r_cfg.dump_code   <= 8'd0;
        end else if (wr_en) begin
            case (reg_idx)
                sfpf_pkg::REG_FIRST_SYNC:  r_cfg.first_sync  <= i_pwdata[7:0];
                sfpf_pkg::REG_SECOND_SYNC: r_cfg.second_sync <= i_pwdata[7:0];
                sfpf_pkg::REG_CMD_MARKER:  r_cfg.cmd_marker  <= i_pwdata[7:0];
                sfpf_pkg::REG_DUMP_MARKER: r_cfg.dump_marker <= i_pwdata[7:0];
                sfpf_pkg::REG_DUMP_CODE:   r_cfg.dump_code   <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sfpf_pkg::REG_FIRST_SYNC:  rd_byte = r_cfg.first_sync;
            sfpf_pkg::REG_SECOND_SYNC: rd_byte = r_cfg.second_sync;
            sfpf_pkg::REG_CMD_MARKER:  rd_byte = r_cfg.cmd_marker;
            sfpf_pkg::REG_DUMP_MARKER: rd_byte = r_cfg.dump_marker;
            sfpf_pkg::REG_DUMP_CODE:   rd_byte = r_cfg.dump_code;
            default:                   rd_byte = 8'd0;
        endcase
    end

    assign o_prdata = {24'd0, rd_byte};
    assign o_cfg    = r_cfg;

endmodule

// File: hdl/sfpf_parser.sv
module sfpf_parser #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfpf_pkg::t_cfg    i_cfg,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output logic              o_emit,
    output sfpf_pkg::t_result o_result
);

    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [sfpf_pkg::LEN_W-1:0] BUF_LEN = sfpf_pkg::LEN_W'(BUFFER_BYTES);

    sfpf_pkg::t_phase              r_phase, n_phase;
    logic [7:0]                    r_sum_a, n_sum_a;
    logic [7:0]                    r_sum_b, n_sum_b;
    logic [31:0]                   r_request, n_request;
    logic [sfpf_pkg::LEN_W-1:0]    r_exp_len, n_exp_len;
    logic [FILL_W-1:0]             r_fill, n_fill;
    logic                          r_is_dump, n_is_dump;
    logic [31:0]                   r_fail_cnt, n_fail_cnt;

    logic [7:0]                    add_a, add_b;
    logic [15:0]                   rows_floats;
    logic [sfpf_pkg::LEN_W-1:0]    dump_len;
    logic [FILL_W-1:0]             fill_inc;
    sfpf_pkg::t_kind               res_kind;
    logic [7:0]                    res_value;
    logic [7:0]                    res_index;
    logic [sfpf_pkg::LEN_W-1:0]    res_len;

    // running fletcher-style sums, modulo 256, with this byte folded in
    assign add_a       = r_sum_a + i_byte;
    assign add_b       = r_sum_b + add_a;
    assign rows_floats = r_exp_len[7:0] * i_byte;
    assign dump_len    = sfpf_pkg::LEN_W'({rows_floats, 2'b00}) + sfpf_pkg::LEN_W'(3);
    assign fill_inc    = r_fill + FILL_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_sum_a    = r_sum_a;
        n_sum_b    = r_sum_b;
        n_request  = r_request;
        n_exp_len  = r_exp_len;
        n_fill     = r_fill;
        n_is_dump  = r_is_dump;
        n_fail_cnt = r_fail_cnt;
        o_emit     = 1'b0;
        res_kind   = sfpf_pkg::KIND_BYTE;
        res_value  = 8'd0;
        res_index  = 8'd0;
        res_len    = r_exp_len;
        case (r_phase)
            sfpf_pkg::PH_SYNC2: begin
                n_phase = (i_byte == i_cfg.second_sync) ? sfpf_pkg::PH_SYNC3
                                                        : sfpf_pkg::PH_SYNC1;
            end
            sfpf_pkg::PH_SYNC3: begin
                n_sum_a = 8'd0;
                n_sum_b = 8'd0;
                // command marker wins when both markers match
                if (i_byte == i_cfg.cmd_marker) begin
                    n_is_dump = 1'b0;
                    n_exp_len = '0;
                    n_phase   = sfpf_pkg::PH_RQID1;
                end else if (i_byte == i_cfg.dump_marker) begin
                    n_is_dump = 1'b1;
                    n_exp_len = '0;
                    n_fill    = FILL_W'(1);
                    n_phase   = sfpf_pkg::PH_ROWS;
                    o_emit    = 1'b1;
                    res_value = i_cfg.dump_code;
                    res_len   = '0;
                end else begin
                    n_phase = sfpf_pkg::PH_SYNC1;
                end
            end
            sfpf_pkg::PH_RQID1: begin
                n_sum_a   = add_a;
                n_sum_b   = add_b;
                n_request = {r_request[31:8], i_byte};
                n_phase   = sfpf_pkg::PH_RQID2;
            end
            sfpf_pkg::PH_RQID2: begin
                n_sum_a   = add_a;
                n_sum_b   = add_b;
                n_request = {r_request[31:16], i_byte, r_request[7:0]};
                n_phase   = sfpf_pkg::PH_RQID3;
            end
            sfpf_pkg::PH_RQID3: begin
                n_sum_a   = add_a;
                n_sum_b   = add_b;
                n_request = {r_request[31:24], i_byte, r_request[15:0]};
                n_phase   = sfpf_pkg::PH_RQID4;
            end
            sfpf_pkg::PH_RQID4: begin
                n_sum_a   = add_a;
                n_sum_b   = add_b;
                n_request = {i_byte, r_request[23:0]};
                n_phase   = sfpf_pkg::PH_LEN;
            end
            sfpf_pkg::PH_LEN: begin
                n_sum_a   = add_a;
                n_sum_b   = add_b;
                n_exp_len = sfpf_pkg::LEN_W'(i_byte);
                n_fill    = '0;
                if (i_byte == 8'd0 || sfpf_pkg::LEN_W'(i_byte) > BUF_LEN) begin
                    n_phase  = sfpf_pkg::PH_SYNC1;
                    o_emit   = 1'b1;
                    res_kind = sfpf_pkg::KIND_LEN;
                    res_len  = sfpf_pkg::LEN_W'(i_byte);
                end else begin
                    n_phase = sfpf_pkg::PH_PAYLOAD;
                end
            end
            sfpf_pkg::PH_ROWS: begin
                n_sum_a   = add_a;
                n_sum_b   = add_b;
                n_exp_len = sfpf_pkg::LEN_W'(i_byte);
                n_fill    = FILL_W'(2);
                n_phase   = sfpf_pkg::PH_FLOATS;
                o_emit    = 1'b1;
                res_value = i_byte;
                res_index = 8'd1;
                res_len   = '0;
            end
            sfpf_pkg::PH_FLOATS: begin
                n_sum_a   = add_a;
                n_sum_b   = add_b;
                n_exp_len = dump_len;
                n_fill    = FILL_W'(3);
                o_emit    = 1'b1;
                res_len   = dump_len;
                // no float bytes, or more than the buffer holds
                if (dump_len <= sfpf_pkg::LEN_W'(3) || dump_len > BUF_LEN) begin
                    n_phase  = sfpf_pkg::PH_SYNC1;
                    res_kind = sfpf_pkg::KIND_LEN;
                end else begin
                    n_phase   = sfpf_pkg::PH_PAYLOAD;
                    res_value = i_byte;
                    res_index = 8'd2;
                end
            end
            sfpf_pkg::PH_PAYLOAD: begin
                n_sum_a   = add_a;
                n_sum_b   = add_b;
                n_fill    = fill_inc;
                if (sfpf_pkg::LEN_W'(fill_inc) >= r_exp_len) begin
                    n_phase = sfpf_pkg::PH_CHECK1;
                end
                o_emit    = 1'b1;
                res_value = i_byte;
                res_index = 8'(r_fill);
            end
            sfpf_pkg::PH_CHECK1: begin
                if (i_byte == r_sum_a) begin
                    n_phase = sfpf_pkg::PH_CHECK2;
                end else begin
                    n_phase    = sfpf_pkg::PH_SYNC1;
                    n_fail_cnt = r_fail_cnt + 32'd1;
                    o_emit     = 1'b1;
                    res_kind   = sfpf_pkg::KIND_CSUM;
                end
            end
            sfpf_pkg::PH_CHECK2: begin
                n_phase = sfpf_pkg::PH_SYNC1;
                o_emit  = 1'b1;
                if (i_byte == r_sum_b) begin
                    res_kind = sfpf_pkg::KIND_GOOD;
                end else begin
                    n_fail_cnt = r_fail_cnt + 32'd1;
                    res_kind   = sfpf_pkg::KIND_CSUM;
                end
            end
            default: begin
                // hunting for the first sync byte, unused codes land here too
                n_phase = (i_byte == i_cfg.first_sync) ? sfpf_pkg::PH_SYNC2
                                                       : sfpf_pkg::PH_SYNC1;
            end
        endcase
    end

    always_comb begin
        o_result.result_kind  = res_kind;
        o_result.frame_type   = n_is_dump;
        o_result.byte_value   = res_value;
        o_result.byte_index   = res_index;
        o_result.request_tag  = n_is_dump ? 32'd0 : n_request;
        o_result.frame_length = res_len;
        o_result.error_total  = n_fail_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= sfpf_pkg::PH_SYNC1;
            r_sum_a    <= 8'd0;
            r_sum_b    <= 8'd0;
            r_request  <= 32'd0;
            r_exp_len  <= '0;
            r_fill     <= '0;
            r_is_dump  <= 1'b0;
            r_fail_cnt <= 32'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_sum_a    <= n_sum_a;
            r_sum_b    <= n_sum_b;
            r_request  <= n_request;
            r_exp_len  <= n_exp_len;
            r_fill     <= n_fill;
            r_is_dump  <= n_is_dump;
            r_fail_cnt <= n_fail_cnt;
        end
    end

endmodule

// File: hdl/sfpf_out_reg.sv
module sfpf_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sfpf_pkg::t_result i_result,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output sfpf_pkg::t_result o_result
);

    logic              r_valid;
    sfpf_pkg::t_result r_result;

    // a waiting result is replaced in the same cycle it is taken
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: hdl/sync_frame_parser_fletcher.sv
// path: a byte is held in the input register on transfer, and the parser step loads
// its result into the result register once that register can take it
// throughput: one byte per cycle, the parser step being combinational between the two
// registers; a result waiting on the master side and not taken holds the input register
// reset: synchronous active-low i_rst_n; parser hunts for the first sync byte,
// sums, request id, length and error count are cleared, valid flags and config take reset values
`include "sync_frame_parser_fletcher_defines.svh"

module sync_frame_parser_fletcher #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave side
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] rx_byte
    // master side
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [7:0] byte_value, [15:8] byte_index, [47:16] request_tag,
    // [65:48] frame_length, [97:66] error_total, [103:98] zero
    output logic [103:0]                o_m_tdata,
    output logic [2:0]                  o_m_tuser,   // [1:0] result_kind, [2] frame_type
    // configuration
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [sfpf_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output logic [31:0]                 o_prdata,
    output logic                        o_pready
);

    localparam logic [sfpf_pkg::LEN_W-1:0] BUF_LEN = sfpf_pkg::LEN_W'(BUFFER_BYTES);

    sfpf_pkg::t_cfg    cfg;
    sfpf_pkg::t_result step_result;
    sfpf_pkg::t_result out_result;
    logic              step_emit;
    logic              can_load;
    logic              advance;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              out_is_payload;
    logic              out_is_end;
    logic              out_len_ok;
    logic              out_pos_zero;

    sfpf_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    // held byte moves on once the result register can take its result
    assign advance    = r_in_valid && can_load;
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    sfpf_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    sfpf_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && step_emit),
        .i_result   (step_result),
        .o_can_load (can_load),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_result   (out_result)
    );

    assign o_m_tdata = {6'd0,
                        out_result.error_total,
                        out_result.frame_length,
                        out_result.request_tag,
                        out_result.byte_index,
                        out_result.byte_value};
    assign o_m_tuser = {out_result.frame_type, out_result.result_kind};

    assign out_is_payload = o_m_tvalid && out_result.result_kind == sfpf_pkg::KIND_BYTE;
    assign out_is_end     = o_m_tvalid && out_result.result_kind != sfpf_pkg::KIND_BYTE;
    assign out_len_ok     = out_result.frame_length <= BUF_LEN;
    assign out_pos_zero   = out_result.byte_value == 8'd0 && out_result.byte_index == 8'd0;

    `SFPF_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)

    `SFPF_ASSERT_NEXT(a_transfer_held, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_in_valid)

    `SFPF_ASSERT_IMPLY(a_payload_len_bound, i_clk, i_rst_n, out_is_payload, out_len_ok)

    `SFPF_ASSERT_IMPLY(a_end_fields_zero, i_clk, i_rst_n, out_is_end, out_pos_zero)

endmodule

// File: test/tb.sv
module tb;

    localparam int BUFFER_BYTES  = 256;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [7:0]                    i_s_tdata;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [103:0]                  o_m_tdata;
    logic [2:0]                    o_m_tuser;
    logic                          i_psel;
    logic                          i_penable;
    logic                          i_pwrite;
    logic [sfpf_pkg::ADDR_W-1:0]   i_paddr;
    logic [31:0]                   i_pwdata;
    logic [31:0]                   o_prdata;
    logic                          o_pready;

    sync_frame_parser_fletcher #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // tracks the parser byte by byte and holds the results it should produce
    class frame_scoreboard;
        logic [7:0]        sync_a;
        logic [7:0]        sync_b;
        logic [7:0]        cmd_mark;
        logic [7:0]        dump_mark;
        logic [7:0]        dump_code;
        sfpf_pkg::t_phase  phase;
        logic [7:0]        sum_a;
        logic [7:0]        sum_b;
        logic [31:0]       req_id;
        int                exp_len;
        int                fill;
        bit                is_dump;
        logic [31:0]       csum_fails;
        sfpf_pkg::t_result expected_q[$];
        int                mismatches;
        int                checked;
        int                kind_seen[4];

        function new();
            sync_a     = 8'd65;
            sync_b     = 8'd113;
            cmd_mark   = 8'd67;
            dump_mark  = 8'd70;
            dump_code  = 8'd0;
            phase      = sfpf_pkg::PH_SYNC1;
            sum_a      = 8'd0;
            sum_b      = 8'd0;
            req_id     = 32'd0;
            exp_len    = 0;
            fill       = 0;
            is_dump    = 1'b0;
            csum_fails = 32'd0;
            mismatches = 0;
            checked    = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] v);
            case (idx)
                sfpf_pkg::REG_FIRST_SYNC:  sync_a = v;
                sfpf_pkg::REG_SECOND_SYNC: sync_b = v;
                sfpf_pkg::REG_CMD_MARKER:  cmd_mark = v;
                sfpf_pkg::REG_DUMP_MARKER: dump_mark = v;
                sfpf_pkg::REG_DUMP_CODE:   dump_code = v;
                default: ;
            endcase
        endfunction

        function void push_result(sfpf_pkg::t_kind k, logic [7:0] v, logic [7:0] idx,
                                  int len);
            sfpf_pkg::t_result r;
            r.result_kind  = k;
            r.frame_type   = is_dump;
            r.byte_value   = v;
            r.byte_index   = idx;
            r.request_tag  = is_dump ? 32'd0 : req_id;
            r.frame_length = len[sfpf_pkg::LEN_W-1:0];
            r.error_total  = csum_fails;
            expected_q.push_back(r);
        endfunction

        function void add_sum(logic [7:0] b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function void note_byte(logic [7:0] b);
            int pos;
            case (phase)
                sfpf_pkg::PH_SYNC2: begin
                    phase = (b == sync_b) ? sfpf_pkg::PH_SYNC3 : sfpf_pkg::PH_SYNC1;
                end
                sfpf_pkg::PH_SYNC3: begin
                    sum_a = 8'd0;
                    sum_b = 8'd0;
                    // command marker wins when both markers are equal
                    if (b == cmd_mark) begin
                        is_dump = 1'b0;
                        exp_len = 0;
                        phase   = sfpf_pkg::PH_RQID1;
                    end else if (b == dump_mark) begin
                        is_dump = 1'b1;
                        exp_len = 0;
                        fill    = 1;
                        phase   = sfpf_pkg::PH_ROWS;
                        push_result(sfpf_pkg::KIND_BYTE, dump_code, 8'd0, 0);
                    end else begin
                        phase = sfpf_pkg::PH_SYNC1;
                    end
                end
                sfpf_pkg::PH_RQID1, sfpf_pkg::PH_RQID2,
                sfpf_pkg::PH_RQID3, sfpf_pkg::PH_RQID4: begin
                    add_sum(b);
                    pos = (int'(phase) - int'(sfpf_pkg::PH_RQID1)) * 8;
                    req_id[pos +: 8] = b;
                    phase = (phase == sfpf_pkg::PH_RQID4) ? sfpf_pkg::PH_LEN
                                                          : sfpf_pkg::t_phase'(int'(phase) + 1);
                end
                sfpf_pkg::PH_LEN: begin
                    add_sum(b);
                    exp_len = b;
                    fill    = 0;
                    if (b == 8'd0 || int'(b) > BUFFER_BYTES) begin
                        phase = sfpf_pkg::PH_SYNC1;
                        push_result(sfpf_pkg::KIND_LEN, 8'd0, 8'd0, exp_len);
                    end else begin
                        phase = sfpf_pkg::PH_PAYLOAD;
                    end
                end
                sfpf_pkg::PH_ROWS: begin
                    add_sum(b);
                    exp_len = b;
                    fill    = 2;
                    phase   = sfpf_pkg::PH_FLOATS;
                    push_result(sfpf_pkg::KIND_BYTE, b, 8'd1, 0);
                end
                sfpf_pkg::PH_FLOATS: begin
                    add_sum(b);
                    exp_len = 3 + exp_len * int'(b) * 4;
                    fill    = 3;
                    if (exp_len <= 3 || exp_len > BUFFER_BYTES) begin
                        phase = sfpf_pkg::PH_SYNC1;
                        push_result(sfpf_pkg::KIND_LEN, 8'd0, 8'd0, exp_len);
                    end else begin
                        phase = sfpf_pkg::PH_PAYLOAD;
                        push_result(sfpf_pkg::KIND_BYTE, b, 8'd2, exp_len);
                    end
                end
                sfpf_pkg::PH_PAYLOAD: begin
                    add_sum(b);
                    pos  = fill;
                    fill = pos + 1;
                    if (fill >= exp_len) phase = sfpf_pkg::PH_CHECK1;
                    push_result(sfpf_pkg::KIND_BYTE, b, pos[7:0], exp_len);
                end
                sfpf_pkg::PH_CHECK1: begin
                    if (b == sum_a) begin
                        phase = sfpf_pkg::PH_CHECK2;
                    end else begin
                        // second check byte is not awaited
                        phase = sfpf_pkg::PH_SYNC1;
                        csum_fails++;
                        push_result(sfpf_pkg::KIND_CSUM, 8'd0, 8'd0, exp_len);
                    end
                end
                sfpf_pkg::PH_CHECK2: begin
                    phase = sfpf_pkg::PH_SYNC1;
                    if (b == sum_b) begin
                        push_result(sfpf_pkg::KIND_GOOD, 8'd0, 8'd0, exp_len);
                    end else begin
                        csum_fails++;
                        push_result(sfpf_pkg::KIND_CSUM, 8'd0, 8'd0, exp_len);
                    end
                end
                default: phase = (b == sync_a) ? sfpf_pkg::PH_SYNC2 : sfpf_pkg::PH_SYNC1;
            endcase
        endfunction

        function void check_result(logic [103:0] data, logic [2:0] user);
            sfpf_pkg::t_result got;
            sfpf_pkg::t_result want;
            got.result_kind  = sfpf_pkg::t_kind'(user[1:0]);
            got.frame_type   = user[2];
            got.byte_value   = data[7:0];
            got.byte_index   = data[15:8];
            got.request_tag  = data[47:16];
            got.frame_length = data[65:48];
            got.error_total  = data[97:66];
            checked++;
            kind_seen[user[1:0]]++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d value %02h index %0d len %0d",
                             got.result_kind, got.byte_value, got.byte_index,
                             got.frame_length);
                return;
            end
            want = expected_q.pop_front();
            if (got.result_kind !== want.result_kind || got.frame_type !== want.frame_type ||
                got.byte_value !== want.byte_value || got.byte_index !== want.byte_index ||
                got.request_tag !== want.request_tag ||
                got.frame_length !== want.frame_length ||
                got.error_total !== want.error_total || data[103:98] !== 6'd0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected kind %0d type %0d value %02h index %0d ",
                             want.result_kind, want.frame_type, want.byte_value,
                             want.byte_index, "tag %08h len %0d errs %0d",
                             want.request_tag, want.frame_length, want.error_total);
                    $display("          actual   kind %0d type %0d value %02h index %0d ",
                             got.result_kind, got.frame_type, got.byte_value,
                             got.byte_index, "tag %08h len %0d errs %0d pad %02h",
                             got.request_tag, got.frame_length, got.error_total,
                             data[103:98]);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    frame_scoreboard sb = new();

    logic [7:0] frame_q[$];
    logic [7:0] run_a;
    logic [7:0] run_b;
    bit         calm;
    int         frame_bytes;
    int         cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycles, sb.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // sink back-pressure
    always @(negedge i_clk) begin
        i_m_tready = !i_rst_n || calm || ($urandom_range(0, 99) >= 15);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata, o_m_tuser);
    end

    function void put_summed(logic [7:0] b);
        frame_q.push_back(b);
        run_a = run_a + b;
        run_b = run_b + run_a;
    endfunction

    function void put_header(logic [7:0] marker);
        frame_q.push_back(sb.sync_a);
        frame_q.push_back(sb.sync_b);
        frame_q.push_back(marker);
        run_a = 8'd0;
        run_b = 8'd0;
    endfunction

    // bad: 0 good check bytes, 1 wrong first, 2 wrong second
    function void put_checks(int bad);
        if (bad == 1) begin
            frame_q.push_back(run_a ^ 8'($urandom_range(1, 255)));
        end else begin
            frame_q.push_back(run_a);
            frame_q.push_back(bad == 2 ? run_b ^ 8'($urandom_range(1, 255)) : run_b);
        end
    endfunction

    function void build_cmd(logic [31:0] tag, logic [7:0] len, int bad);
        put_header(sb.cmd_mark);
        for (int i = 0; i < 4; i++) put_summed(tag[8*i +: 8]);
        put_summed(len);
        if (len != 8'd0) begin
            for (int i = 0; i < len; i++) put_summed(8'($urandom));
            put_checks(bad);
        end
    endfunction

    function void build_dump(logic [7:0] rows, logic [7:0] floats, int bad);
        int n;
        n = int'(rows) * int'(floats) * 4;
        put_header(sb.dump_mark);
        put_summed(rows);
        put_summed(floats);
        if (n > 0 && n + 3 <= BUFFER_BYTES) begin
            for (int i = 0; i < n; i++) put_summed(8'($urandom));
            put_checks(bad);
        end
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 99) < 15) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                i_s_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_byte(b);
        @(negedge i_clk);
    endtask

    // counted: bytes that belong to frames, as opposed to line noise
    task automatic send_queue(bit counted);
        while (frame_q.size() != 0) begin
            send_byte(frame_q.pop_front());
            if (counted) frame_bytes++;
        end
    endtask

    task automatic settle();
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] v);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b1;
        i_paddr   = {idx, 2'b00};
        i_pwdata  = {24'd0, v};
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
    endtask

    task automatic load_config(logic [7:0] s1, logic [7:0] s2, logic [7:0] cm,
                               logic [7:0] dm, logic [7:0] dc);
        write_reg(sfpf_pkg::REG_FIRST_SYNC, s1);
        write_reg(sfpf_pkg::REG_SECOND_SYNC, s2);
        write_reg(sfpf_pkg::REG_CMD_MARKER, cm);
        write_reg(sfpf_pkg::REG_DUMP_MARKER, dm);
        write_reg(sfpf_pkg::REG_DUMP_CODE, dc);
    endtask

    task automatic directed_frames();
        logic [7:0] shared;
        build_cmd(32'h0000_0000, 8'd1, 0);            send_queue(1);
        build_cmd(32'hFFFF_FFFF, 8'd255, 0);          send_queue(1);
        build_cmd(32'h1234_5678, 8'd0, 0);            send_queue(1);
        build_cmd($urandom, 8'd5, 1);                 send_queue(1);
        build_cmd($urandom, 8'd5, 2);                 send_queue(1);
        build_dump(8'd1, 8'd1, 0);                    send_queue(1);
        build_dump(8'd7, 8'd9, 0);                    send_queue(1);
        build_dump(8'd0, 8'd5, 0);                    send_queue(1);
        build_dump(8'd4, 8'd0, 0);                    send_queue(1);
        build_dump(8'd255, 8'd255, 0);                send_queue(1);
        build_dump(8'd8, 8'd8, 0);                    send_queue(1);
        build_dump(8'd2, 8'd3, 2);                    send_queue(1);
        build_dump(8'd1, 8'd2, 1);                    send_queue(1);
        // bad second sync: the repeated first sync byte must not restart the hunt
        frame_q.push_back(sb.sync_a);
        frame_q.push_back(sb.sync_a);
        frame_q.push_back(sb.sync_b);
        frame_q.push_back(sb.cmd_mark);
        send_queue(0);
        build_cmd($urandom, 8'd3, 0);                 send_queue(1);
        // unknown frame type marker
        frame_q.push_back(sb.sync_a);
        frame_q.push_back(sb.sync_b);
        frame_q.push_back(8'h00);
        send_queue(0);
        build_dump(8'd1, 8'd3, 0);                    send_queue(1);
        // both markers equal: command frame takes precedence
        shared = sb.dump_mark;
        settle();
        write_reg(sfpf_pkg::REG_DUMP_MARKER, sb.cmd_mark);
        build_cmd(32'hA5A5_5A5A, 8'd4, 0);            send_queue(1);
        settle();
        write_reg(sfpf_pkg::REG_DUMP_MARKER, shared);
    endtask

    task automatic random_traffic(int budget);
        int start;
        int pick;
        int bad;
        int cut;
        logic [7:0] len;
        logic [7:0] v;
        start = frame_bytes;
        while (frame_bytes - start < budget) begin
            pick = $urandom_range(0, 99);
            bad  = $urandom_range(0, 99);
            bad  = (bad < 10) ? 1 : (bad < 20) ? 2 : 0;
            if (pick < 40) begin
                len = ($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(1, 12));
                if ($urandom_range(0, 99) < 3) len = 8'd0;
                build_cmd($urandom, len, bad);
                send_queue(1);
            end else if (pick < 70) begin
                if ($urandom_range(0, 99) < 10)
                    build_dump(8'($urandom), 8'($urandom), bad);
                else
                    build_dump(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), bad);
                send_queue(1);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
                send_queue(0);
            end else if (pick < 90) begin
                frame_q.push_back(sb.sync_a);
                if ($urandom_range(0, 1)) begin
                    v = 8'($urandom);
                    if (v == sb.sync_b) v = v ^ 8'h01;
                    frame_q.push_back(v);
                end else begin
                    frame_q.push_back(sb.sync_b);
                    v = 8'($urandom);
                    while (v == sb.cmd_mark || v == sb.dump_mark) v = v + 8'd1;
                    frame_q.push_back(v);
                end
                send_queue(0);
            end else begin
                // frame cut short, the next frame runs into it
                build_cmd($urandom, 8'($urandom_range(1, 12)), 0);
                cut = $urandom_range(1, frame_q.size() - 4);
                repeat (cut) void'(frame_q.pop_back());
                send_queue(1);
            end
        end
    endtask

    initial begin
        logic [7:0] mark;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = 8'd0;
        i_psel      = 1'b0;
        i_penable   = 1'b0;
        i_pwrite    = 1'b0;
        i_paddr     = '0;
        i_pwdata    = 32'd0;
        calm        = 1'b0;
        frame_bytes = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        load_config(8'd65, 8'd113, 8'd67, 8'd70, 8'd0);
        directed_frames();
        random_traffic(60);

        settle();
        load_config(8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF);
        random_traffic(100);

        settle();
        load_config(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h5A);
        calm = 1'b1;
        random_traffic(80);
        calm = 1'b0;
        random_traffic(40);

        settle();
        mark = 8'($urandom);
        load_config(8'($urandom), 8'($urandom), mark,
                    mark ^ 8'($urandom_range(1, 255)), 8'($urandom));
        random_traffic(80);

        settle();
        $display("%0d frame bytes over four register settings, %0d results checked, ",
                 frame_bytes, sb.checked, "%0d mismatches", sb.mismatches);
        $display("outcomes seen: %0d payload bytes, %0d good frames, ",
                 sb.kind_seen[sfpf_pkg::KIND_BYTE], sb.kind_seen[sfpf_pkg::KIND_GOOD],
                 "%0d checksum errors, %0d length errors",
                 sb.kind_seen[sfpf_pkg::KIND_CSUM], sb.kind_seen[sfpf_pkg::KIND_LEN]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
